@@ rtl/core/swdt_pkg.sv @@
// Shared types and constants for the Super I/O style watchdog timer.
package swdt_pkg;

    localparam logic [7:0]  KEY_ENTER     = 8'h87;
    localparam logic [7:0]  KEY_EXIT      = 8'hAA;
    localparam logic [7:0]  REG_DEVSEL    = 8'h07;
    localparam logic [7:0]  REG_ID_HI     = 8'h20;
    localparam logic [7:0]  REG_ID_LO     = 8'h21;
    localparam logic [7:0]  REG_ACTIVE    = 8'h30;
    localparam logic [7:0]  REG_MODE      = 8'hF0;
    localparam logic [7:0]  REG_COUNT     = 8'hF1;
    localparam logic [7:0]  REG_CTRL      = 8'hF2;
    localparam logic [7:0]  DEV_WATCHDOG  = 8'h08;
    localparam int unsigned EVENT_BIT     = 4;
    localparam logic [7:0]  READ_NONE     = 8'hFF;
    localparam logic [15:0] CHIP_ID_RESET = 16'hC453;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        KEY_LOCKED = 2'd0,
        KEY_HALF   = 2'd1,
        KEY_OPEN   = 2'd2
    } t_key_state;

    // Decoded access strobes, already qualified by the pipeline advance.
    typedef struct packed {
        logic       idx_wr;
        logic       sel_wr;
        logic       dat_wr;
        logic       tick;
        logic [7:0] data;
    } t_acc;

endpackage

@@ rtl/core/swdt_ifs.sv @@
// Valid/ready channel interfaces for the watchdog input, result and config ports.
interface swdt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       port_select;
    logic [7:0] write_data;

    modport source (output valid, output opcode, output port_select, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input port_select, input write_data,
                    output ready);
endinterface

interface swdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       timeout_event;
    logic       unlocked;

    modport source (output valid, output read_data, output timeout_event, output unlocked,
                    input ready);
    modport sink   (input valid, input read_data, input timeout_event, input unlocked,
                    output ready);
endinterface

interface swdt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] chip_id;

    modport source (output valid, output chip_id, input ready);
    modport sink   (input valid, input chip_id, output ready);
endinterface

@@ rtl/core/superio_watchdog_timer.sv @@
// Super I/O style watchdog timer: input register, access decode, result register.
// A result passes from the input register to the result register, which drives the output.
// Throughput: one item per cycle unless output stalls; each is a register read-modify-write.
// A waiting result holds the input register; an empty input register still takes one transfer.
// Synchronous active-low reset locks configuration mode, clears the valid flags, the config
// registers and the timer, and loads the default chip ID.
module superio_watchdog_timer (
    input  logic  i_clk,
    input  logic  i_rst_n,
    swdt_in_if.sink    i_in,
    swdt_cfg_if.sink   i_cfg,
    swdt_out_if.source o_out
);

    logic        r_in_valid;
    logic [1:0]  r_in_opcode;
    logic        r_in_port;
    logic [7:0]  r_in_data;

    logic        r_out_valid;
    logic [7:0]  r_out_rd;
    logic        r_out_event;
    logic        r_out_unlocked;

    logic [15:0] r_chip_id;

    logic           w_adv;
    logic           w_unlocked;
    logic           w_n_unlocked;
    logic [7:0]     w_reg_rd;
    logic           w_expired;
    logic           w_n_expired;
    logic [7:0]     w_rd;
    swdt_pkg::t_acc w_acc;

    assign w_adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready   = !r_in_valid || w_adv;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_chip_id   <= swdt_pkg::CHIP_ID_RESET;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) r_chip_id <= i_cfg.chip_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_opcode <= i_in.opcode;
            r_in_port   <= i_in.port_select;
            r_in_data   <= i_in.write_data;
        end
        if (w_adv) begin
            r_out_rd       <= w_rd;
            r_out_event    <= w_n_expired;
            r_out_unlocked <= w_n_unlocked;
        end
    end

    always_comb begin
        w_acc.data   = r_in_data;
        w_acc.idx_wr = w_adv && (r_in_opcode == swdt_pkg::OP_WRITE) && !r_in_port;
        w_acc.sel_wr = w_acc.idx_wr && w_unlocked && (r_in_data != swdt_pkg::KEY_EXIT);
        w_acc.dat_wr = w_adv && (r_in_opcode == swdt_pkg::OP_WRITE) && r_in_port && w_unlocked;
        w_acc.tick   = w_adv && (r_in_opcode == swdt_pkg::OP_TICK);
        w_rd         = 8'd0;
        if (r_in_opcode == swdt_pkg::OP_READ) begin
            w_rd = (r_in_port && w_unlocked) ? w_reg_rd : swdt_pkg::READ_NONE;
        end
    end

    swdt_keyfsm u_keyfsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (w_acc),
        .o_unlocked   (w_unlocked),
        .o_n_unlocked (w_n_unlocked)
    );

    swdt_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_chip_id   (r_chip_id),
        .o_rd_data   (w_reg_rd),
        .o_expired   (w_expired),
        .o_n_expired (w_n_expired)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.read_data     = r_out_rd;
    assign o_out.timeout_event = r_out_event;
    assign o_out.unlocked      = r_out_unlocked;

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed item did not reach the result register");

    a_lock_by_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_unlocked) |-> $past(w_acc.idx_wr))
        else $error("configuration mode left without an index write");

    a_event_by_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_expired) |-> $past(w_acc.tick))
        else $error("timeout event set without a tick");

endmodule

@@ rtl/core/swdt_keyfsm.sv @@
// Key sequence state machine that unlocks and locks configuration mode.
module swdt_keyfsm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  swdt_pkg::t_acc i_acc,
    output logic          o_unlocked,
    output logic          o_n_unlocked
);

    swdt_pkg::t_key_state r_state;
    swdt_pkg::t_key_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swdt_pkg::KEY_LOCKED;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_acc.idx_wr) begin
            case (r_state)
                swdt_pkg::KEY_OPEN: begin
                    if (i_acc.data == swdt_pkg::KEY_EXIT) n_state = swdt_pkg::KEY_LOCKED;
                end
                swdt_pkg::KEY_HALF: begin
                    n_state = (i_acc.data == swdt_pkg::KEY_ENTER) ? swdt_pkg::KEY_OPEN
                                                                  : swdt_pkg::KEY_LOCKED;
                end
                swdt_pkg::KEY_LOCKED: begin
                    n_state = (i_acc.data == swdt_pkg::KEY_ENTER) ? swdt_pkg::KEY_HALF
                                                                  : swdt_pkg::KEY_LOCKED;
                end
                default: begin
                    n_state = swdt_pkg::KEY_LOCKED;
                end
            endcase
        end
        o_unlocked   = (r_state == swdt_pkg::KEY_OPEN);
        o_n_unlocked = (n_state == swdt_pkg::KEY_OPEN);
    end

endmodule

@@ rtl/core/swdt_regfile.sv @@
// Configuration registers, logical-device decode and the watchdog down counter.
module swdt_regfile (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  swdt_pkg::t_acc i_acc,
    input  logic [15:0]    i_chip_id,
    output logic [7:0]     o_rd_data,
    output logic           o_expired,
    output logic           o_n_expired
);

    logic [7:0] r_reg_index;
    logic [7:0] r_dev_sel;
    logic       r_active;
    logic [7:0] r_mode;
    logic [7:0] r_count;
    logic       r_expired;

    logic [7:0] n_reg_index;
    logic [7:0] n_dev_sel;
    logic       n_active;
    logic [7:0] n_mode;
    logic [7:0] n_count;
    logic       n_expired;
    logic       w_wdt_sel;
    logic [7:0] w_count_dec;

    assign w_wdt_sel   = (r_dev_sel == swdt_pkg::DEV_WATCHDOG);
    assign w_count_dec = r_count - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_index <= '0;
            r_dev_sel   <= '0;
            r_active    <= 1'b0;
            r_mode      <= '0;
            r_count     <= '0;
            r_expired   <= 1'b0;
        end else begin
            r_reg_index <= n_reg_index;
            r_dev_sel   <= n_dev_sel;
            r_active    <= n_active;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_expired   <= n_expired;
        end
    end

    always_comb begin
        n_reg_index = r_reg_index;
        n_dev_sel   = r_dev_sel;
        n_active    = r_active;
        n_mode      = r_mode;
        n_count     = r_count;
        n_expired   = r_expired;

        if (i_acc.sel_wr) n_reg_index = i_acc.data;

        if (i_acc.dat_wr) begin
            if (r_reg_index == swdt_pkg::REG_DEVSEL) begin
                n_dev_sel = i_acc.data;
            end else if (w_wdt_sel) begin
                case (r_reg_index)
                    swdt_pkg::REG_ACTIVE: n_active = i_acc.data[0];
                    swdt_pkg::REG_MODE:   n_mode   = i_acc.data;
                    swdt_pkg::REG_COUNT:  n_count  = i_acc.data;
                    swdt_pkg::REG_CTRL: begin
                        // event is write-zero-to-clear
                        if (!i_acc.data[swdt_pkg::EVENT_BIT]) n_expired = 1'b0;
                    end
                    default: ;
                endcase
            end
        end

        // advance the countdown; flag the event on reaching zero
        if (i_acc.tick && r_active && (r_count != 8'd0)) begin
            n_count = w_count_dec;
            if (w_count_dec == 8'd0) n_expired = 1'b1;
        end
    end

    always_comb begin
        o_rd_data = swdt_pkg::READ_NONE;
        case (r_reg_index)
            swdt_pkg::REG_DEVSEL: o_rd_data = r_dev_sel;
            swdt_pkg::REG_ID_HI:  o_rd_data = i_chip_id[15:8];
            swdt_pkg::REG_ID_LO:  o_rd_data = i_chip_id[7:0];
            swdt_pkg::REG_ACTIVE: if (w_wdt_sel) o_rd_data = {7'd0, r_active};
            swdt_pkg::REG_MODE:   if (w_wdt_sel) o_rd_data = r_mode;
            swdt_pkg::REG_COUNT:  if (w_wdt_sel) o_rd_data = r_count;
            swdt_pkg::REG_CTRL:   if (w_wdt_sel) o_rd_data = {3'd0, r_expired, 4'd0};
            default:              o_rd_data = swdt_pkg::READ_NONE;
        endcase
    end

    assign o_expired   = r_expired;
    assign o_n_expired = n_expired;

endmodule
